// ===== src/itoa_pkg.sv =====
// shared types, constants and place-value table for the integer to ascii converter
package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 6;
   localparam int DIGIT_COUNT = 10;
   localparam int POS_WIDTH   = 4;
   localparam int STEP_WIDTH  = 34;

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
   } itoa_entry_type;

   // mult times ten to the power pos, mult is a constant at every call site
   function automatic logic [STEP_WIDTH-1:0] step_value(input logic [POS_WIDTH-1:0] pos,
                                                         input logic [3:0] mult);
      logic [STEP_WIDTH-1:0] base;
      case (pos)
         4'd0:    base = 34'd1;
         4'd1:    base = 34'd10;
         4'd2:    base = 34'd100;
         4'd3:    base = 34'd1000;
         4'd4:    base = 34'd10000;
         4'd5:    base = 34'd100000;
         4'd6:    base = 34'd1000000;
         4'd7:    base = 34'd10000000;
         4'd8:    base = 34'd100000000;
         4'd9:    base = 34'd1000000000;
         default: base = '0;
      endcase
      return base * {{(STEP_WIDTH-4){1'b0}}, mult};
   endfunction

endpackage

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// top level of the signed 32-bit integer to decimal ascii converter
// the value's beat is written into the queue, the back-end sequencer loads it from there, then
//   the first character (the sign of a negative value) goes into the output register; a positive
//   value's first digit follows only once its leading zero places have been stepped over
// the back-end sequencer resolves one decimal place per cycle over all ten places while the
//   output register is free, and takes a new value only once it is back in idle
// reset: synchronous, clears the queue, the sequencer and the output register's valid flag
module signed_int_to_decimal_ascii_top
   import itoa_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic                   clock,
   input  logic                   reset,
   // value beats in
   input  logic [VALUE_WIDTH-1:0] req_tdata,   // value [31:0]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // character beats out
   output logic [7:0]             rsp_tdata,   // char_code [5:0], zero fill [7:6]
   output logic                   rsp_tlast,   // last character of the number
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready
);

   // classified value handed from front to queue
   logic           push_valid;
   logic           push_ready;
   itoa_entry_type push_entry;

   // queue to back end
   logic           pop_valid;
   logic           pop;
   itoa_entry_type pop_entry;

   // front: sign split and magnitude, takes a beat whenever the queue has room
   itoa_front u_front (
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // queue lets the front keep taking values while the back is still sending
   itoa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   // back: sign beat for a negative value, then digits from the top place down, output register in front of rsp
   itoa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule

// ===== src/itoa_front.sv =====
// front end: splits an incoming value into sign and unsigned magnitude
module itoa_front
   import itoa_pkg::*;
(
   input  logic [VALUE_WIDTH-1:0] req_tdata,   // value
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   push_valid,
   input  logic                   push_ready,
   output itoa_entry_type         push_entry
);

   logic negative;

   assign negative   = req_tdata[VALUE_WIDTH-1];
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   // the most negative value negates to itself, which reads right as unsigned
   assign push_entry.negative  = negative;
   assign push_entry.magnitude = negative ? (~req_tdata + {{(VALUE_WIDTH-1){1'b0}}, 1'b1})
                                          : req_tdata;

endmodule

// ===== src/itoa_queue.sv =====
// short queue of classified values between front and back
module itoa_queue
   import itoa_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  itoa_entry_type push_entry,
   output logic           pop_valid,
   input  logic           pop,
   output itoa_entry_type pop_entry
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR   = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   itoa_entry_type             slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/itoa_back.sv =====
// back end: walks the decimal places from the top and sends one character a beat
module itoa_back
   import itoa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop,
   input  itoa_entry_type pop_entry,
   output logic [7:0]     rsp_tdata,   // char_code [5:0], zero fill [7:6]
   output logic           rsp_tlast,
   output logic           rsp_tvalid,
   input  logic           rsp_tready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type              state_ff;
   logic [VALUE_WIDTH-1:0] mag_ff;
   logic [POS_WIDTH-1:0]   pos_ff;
   logic                   started_ff;
   logic [CHAR_WIDTH-1:0]  char_ff;
   logic                   last_ff;
   logic                   valid_ff;

   logic                   out_free;
   logic [STEP_WIDTH-1:0]  mag_wide;
   logic [3:0]             digit;
   logic [STEP_WIDTH-1:0]  sub_value;
   logic [VALUE_WIDTH-1:0] mag_next;
   logic                   show_digit;
   logic                   load_char;

   assign out_free   = !valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && pop_valid;
   assign rsp_tdata  = {2'b00, char_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tvalid = valid_ff;
   assign mag_wide   = {{(STEP_WIDTH-VALUE_WIDTH){1'b0}}, mag_ff};

   // digit at this place: the largest multiple of the place value not above mag
   always_comb begin
      logic [STEP_WIDTH-1:0] thr;
      digit     = 4'd0;
      sub_value = '0;
      for (int k = 1; k < 10; k++) begin
         thr = step_value(pos_ff, 4'(k));
         if (mag_wide >= thr) begin
            digit     = 4'(k);
            sub_value = thr;
         end
      end
   end

   assign mag_next   = mag_ff - sub_value[VALUE_WIDTH-1:0];
   assign show_digit = started_ff || (digit != 4'd0) || (pos_ff == '0);

   // a new character goes into the output register this cycle
   assign load_char  = out_free &&
                       ((state_ff == ST_SIGN) || ((state_ff == ST_DIGIT) && show_digit));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (load_char) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  mag_ff      <= pop_entry.magnitude;
                  pos_ff      <= POS_WIDTH'(DIGIT_COUNT - 1);
                  started_ff  <= 1'b0;
                  state_ff    <= pop_entry.negative ? ST_SIGN : ST_DIGIT;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  char_ff  <= CHAR_MINUS;
                  last_ff  <= 1'b0;
                  state_ff <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (out_free) begin
                  mag_ff     <= mag_next;
                  started_ff <= started_ff || (digit != 4'd0);
                  // leading zeros are stepped over without a beat
                  if (show_digit) begin
                     char_ff  <= CHAR_ZERO + {2'b00, digit};
                     last_ff  <= (pos_ff == '0);
                  end
                  if (pos_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pos_ff <= pos_ff - 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
